[design/drt_pkg.sv]
// ----------------------------------------------------------------------------
// drt_pkg
// Types and constants shared by the deferred-reclaim slot table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

    localparam int SLOTS_DEF         = 64;
    localparam int RETIRE_FRAMES_DEF = 3;

    localparam int CFG_W    = 7;
    localparam int KEY_W    = 32;
    localparam int RES_W    = 16;
    localparam int GEN_W    = 32;
    localparam int FRAME_W  = 32;
    localparam int SLOT_W   = 6;
    localparam int FREED_W  = 7;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_END   = 2'd1,
        ACT_GET   = 2'd2,
        ACT_FIND  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_HIT   = 2'd0,
        STS_NEW   = 2'd1,
        STS_MISS  = 2'd2,
        STS_FRAME = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [RES_W-1:0]   res;
        logic [GEN_W-1:0]   gen;
        logic [FRAME_W-1:0] last_used;
        logic [FRAME_W-1:0] retire;
        logic               pending;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic               pending;
        logic [RES_W-1:0]   res;
        logic [GEN_W-1:0]   gen;
        logic [FREED_W-1:0] freed;
    } t_result;

endpackage

`default_nettype wire

[design/drt_mem.sv]
// ----------------------------------------------------------------------------
// drt_mem
// Slot entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_mem #(
    parameter int DEPTH = drt_pkg::SLOTS_DEF,
    parameter int AW    = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire drt_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output drt_pkg::t_entry      o_rdata
);

    drt_pkg::t_entry r_mem [DEPTH];
    drt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/drt_seq.sv]
// ----------------------------------------------------------------------------
// drt_seq
// Scan sequencer: walks the entry memory one slot per cycle, modifies and
// writes back, holds the valid bits and the frame counter.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_seq #(
    parameter int SLOTS         = drt_pkg::SLOTS_DEF,
    parameter int RETIRE_FRAMES = drt_pkg::RETIRE_FRAMES_DEF,
    parameter int AW            = 6,
    parameter int CW            = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_vld,
    output logic                             o_in_rdy,
    input  wire drt_pkg::t_action            i_act,
    input  wire logic [drt_pkg::KEY_W-1:0]   i_key,
    input  wire logic [drt_pkg::RES_W-1:0]   i_res,
    input  wire logic [drt_pkg::GEN_W-1:0]   i_gen,
    input  wire logic [drt_pkg::CFG_W-1:0]   i_slots_in_use,
    output logic                             o_res_vld,
    input  wire logic                        i_res_rdy,
    output drt_pkg::t_result                 o_result,
    output logic                             o_mem_we,
    output logic [AW-1:0]                    o_mem_waddr,
    output drt_pkg::t_entry                  o_mem_wdata,
    output logic                             o_mem_re,
    output logic [AW-1:0]                    o_mem_raddr,
    input  wire drt_pkg::t_entry             i_mem_rdata
);

    drt_pkg::t_state                r_state;
    drt_pkg::t_state                n_state;
    drt_pkg::t_action               r_act;
    logic [drt_pkg::KEY_W-1:0]      r_key;
    logic [drt_pkg::RES_W-1:0]      r_res;
    logic [drt_pkg::GEN_W-1:0]      r_gen;
    logic [drt_pkg::FRAME_W-1:0]    r_fc;
    logic                           r_valid [SLOTS];
    logic [CW-1:0]                  r_n;
    logic [CW-1:0]                  r_issue;
    logic                           r_pv;
    logic [AW-1:0]                  r_pidx;
    logic [CW-1:0]                  r_freed;
    logic                           r_free_fnd;
    logic [AW-1:0]                  r_free_idx;
    drt_pkg::t_result               r_result;

    drt_pkg::t_entry                rd_ent;
    logic                           accept;
    logic                           issue;
    logic                           ent_vld;
    logic                           key_eq;
    logic                           res_eq;
    logic                           not_ret;
    logic                           get_hit;
    logic                           find_hit;
    logic                           free_ok;
    logic                           ret_ok;
    logic                           scan_done;
    logic [CW-1:0]                  n_active;

    assign rd_ent    = i_mem_rdata;
    assign accept    = i_in_vld && (r_state == drt_pkg::ST_IDLE);
    assign issue     = (r_state == drt_pkg::ST_SCAN) && (r_issue < r_n);
    assign ent_vld   = r_pv && r_valid[r_pidx];
    assign key_eq    = rd_ent.key == r_key;
    assign res_eq    = rd_ent.res == r_res;
    assign not_ret   = rd_ent.retire == '0;
    assign get_hit   = (r_act == drt_pkg::ACT_GET) && ent_vld && key_eq && res_eq;
    assign find_hit  = (r_act == drt_pkg::ACT_FIND) && ent_vld && key_eq && not_ret;
    assign free_ok   = (r_act == drt_pkg::ACT_BEGIN) && ent_vld && !not_ret &&
                       ((r_fc - rd_ent.retire) >= drt_pkg::FRAME_W'(RETIRE_FRAMES));
    assign ret_ok    = (r_act == drt_pkg::ACT_END) && ent_vld &&
                       (rd_ent.last_used != r_fc) && not_ret;
    assign scan_done = (r_issue == r_n) && !r_pv;
    assign n_active  = (32'(i_slots_in_use) > SLOTS) ? CW'(SLOTS) : CW'(i_slots_in_use);

    always_comb begin
        n_state = r_state;
        case (r_state)
            drt_pkg::ST_IDLE: begin
                if (i_in_vld) begin
                    n_state = drt_pkg::ST_SCAN;
                end
            end
            drt_pkg::ST_SCAN: begin
                if (get_hit || find_hit) begin
                    n_state = drt_pkg::ST_OUT;
                end else if (scan_done) begin
                    n_state = (r_act == drt_pkg::ACT_GET) ? drt_pkg::ST_ALLOC
                                                          : drt_pkg::ST_OUT;
                end
            end
            drt_pkg::ST_ALLOC: begin
                n_state = drt_pkg::ST_OUT;
            end
            drt_pkg::ST_OUT: begin
                if (i_res_rdy) begin
                    n_state = drt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = drt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_rdy    = (r_state == drt_pkg::ST_IDLE);
        o_res_vld   = (r_state == drt_pkg::ST_OUT);
        o_result    = r_result;
        o_mem_re    = issue;
        o_mem_raddr = r_issue[AW-1:0];
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pidx;
        o_mem_wdata = rd_ent;
        case (r_state)
            drt_pkg::ST_SCAN: begin
                if (ret_ok) begin
                    o_mem_we           = 1'b1;
                    o_mem_wdata.retire = r_fc;
                end else if (get_hit) begin
                    o_mem_we              = 1'b1;
                    o_mem_wdata.gen       = r_gen;
                    o_mem_wdata.pending   = rd_ent.pending || (rd_ent.gen != r_gen);
                    o_mem_wdata.last_used = r_fc;
                    o_mem_wdata.retire    = '0;
                end
            end
            drt_pkg::ST_ALLOC: begin
                o_mem_we              = r_free_fnd;
                o_mem_waddr           = r_free_idx;
                o_mem_wdata.key       = r_key;
                o_mem_wdata.res       = r_res;
                o_mem_wdata.gen       = r_gen;
                o_mem_wdata.last_used = r_fc;
                o_mem_wdata.retire    = '0;
                o_mem_wdata.pending   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drt_pkg::ST_IDLE;
            r_fc    <= '0;
            r_pv    <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
            if (accept && (i_act == drt_pkg::ACT_BEGIN)) begin
                r_fc <= r_fc + 1'b1;
            end
            if (free_ok && (r_state == drt_pkg::ST_SCAN)) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if ((r_state == drt_pkg::ST_ALLOC) && r_free_fnd) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act      <= i_act;
            r_key      <= i_key;
            r_res      <= i_res;
            r_gen      <= i_gen;
            r_n        <= n_active;
            r_issue    <= '0;
            r_freed    <= '0;
            r_free_fnd <= 1'b0;
        end
        if (issue) begin
            r_issue <= r_issue + 1'b1;
            r_pidx  <= r_issue[AW-1:0];
        end
        if (r_state == drt_pkg::ST_SCAN) begin
            if (free_ok) begin
                r_freed <= r_freed + 1'b1;
            end
            if (r_pv && !r_valid[r_pidx] && !r_free_fnd) begin
                r_free_fnd <= 1'b1;
                r_free_idx <= r_pidx;
            end
            if (get_hit) begin
                r_result.status  <= drt_pkg::STS_HIT;
                r_result.slot    <= drt_pkg::SLOT_W'(r_pidx);
                r_result.pending <= rd_ent.pending || (rd_ent.gen != r_gen);
                r_result.res     <= rd_ent.res;
                r_result.gen     <= r_gen;
                r_result.freed   <= '0;
            end else if (find_hit) begin
                r_result.status  <= drt_pkg::STS_HIT;
                r_result.slot    <= drt_pkg::SLOT_W'(r_pidx);
                r_result.pending <= rd_ent.pending;
                r_result.res     <= rd_ent.res;
                r_result.gen     <= rd_ent.gen;
                r_result.freed   <= '0;
            end else if (scan_done) begin
                r_result.status  <= (r_act == drt_pkg::ACT_FIND) ? drt_pkg::STS_MISS
                                                                 : drt_pkg::STS_FRAME;
                r_result.slot    <= '0;
                r_result.pending <= 1'b0;
                r_result.res     <= '0;
                r_result.gen     <= '0;
                r_result.freed   <= (r_act == drt_pkg::ACT_BEGIN)
                                    ? drt_pkg::FREED_W'(r_freed) : '0;
            end
        end
        if (r_state == drt_pkg::ST_ALLOC) begin
            if (r_free_fnd) begin
                r_result.status  <= drt_pkg::STS_NEW;
                r_result.slot    <= drt_pkg::SLOT_W'(r_free_idx);
                r_result.pending <= 1'b1;
                r_result.res     <= r_res;
                r_result.gen     <= r_gen;
            end else begin
                r_result.status  <= drt_pkg::STS_MISS;
                r_result.slot    <= '0;
                r_result.pending <= 1'b0;
                r_result.res     <= '0;
                r_result.gen     <= '0;
            end
            r_result.freed <= '0;
        end
    end

endmodule

`default_nettype wire

[design/deferred_reclaim_slot_table.sv]
// ----------------------------------------------------------------------------
// deferred_reclaim_slot_table
// Slot table with frame-delayed reclaim; entries live in one memory and are
// scanned one slot per cycle.
//
//   channel   direction  payload
//   s_axis    in         tuser: action; tdata: key_id, req_resolution,
//                        req_generation
//   m_axis    out        tuser: status; tdata: slot_index, pending_flag,
//                        entry_resolution, entry_generation, freed_count
//   cfg       in         wr_data: slots_in_use
//
// Each item scans the n active slots, n = min of slots_in_use and SLOTS,
// through the single read port of the memory. A get-or-create miss adds an
// allocation state; a hit ends the scan early.
// Reset clears valid bits and the frame counter at once; no clearing pass.
// A finished result waits in the output register; a new item is taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_reclaim_slot_table #(
    parameter int SLOTS         = drt_pkg::SLOTS_DEF,
    parameter int RETIRE_FRAMES = drt_pkg::RETIRE_FRAMES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // key_id, req_resolution, req_generation
    input  wire logic [drt_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // action
    input  wire logic [1:0]                     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // slot_index, pending_flag, entry_resolution, entry_generation,
    // freed_count, zero pad
    output logic [drt_pkg::M_DATA_W-1:0]        o_m_axis_tdata,
    // status
    output logic [1:0]                          o_m_axis_tuser,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [drt_pkg::CFG_W-1:0]      i_cfg_wr_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [drt_pkg::CFG_W-1:0]  r_slots_in_use;
    logic                       r_out_vld;
    drt_pkg::t_result           r_out;

    logic                       res_vld;
    logic                       res_rdy;
    drt_pkg::t_result           result;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    drt_pkg::t_entry            mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    drt_pkg::t_entry            mem_rdata;

    assign res_rdy = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= drt_pkg::CFG_RESET;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slots_in_use <= i_cfg_wr_data;
            end
            if (res_rdy) begin
                r_out_vld <= res_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out <= result;
        end
    end

    drt_seq #(
        .SLOTS         (SLOTS),
        .RETIRE_FRAMES (RETIRE_FRAMES),
        .AW            (AW),
        .CW            (CW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_vld       (i_s_axis_tvalid),
        .o_in_rdy       (o_s_axis_tready),
        .i_act          (drt_pkg::t_action'(i_s_axis_tuser)),
        .i_key          (i_s_axis_tdata[31:0]),
        .i_res          (i_s_axis_tdata[47:32]),
        .i_gen          (i_s_axis_tdata[79:48]),
        .i_slots_in_use (r_slots_in_use),
        .o_res_vld      (res_vld),
        .i_res_rdy      (res_rdy),
        .o_result       (result),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    drt_mem #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {2'b00, r_out.freed, r_out.gen, r_out.res,
                              r_out.pending, r_out.slot};

`ifndef SYNTHESIS
    a_plain_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == drt_pkg::STS_MISS ||
                            o_m_axis_tuser == drt_pkg::STS_FRAME)
        |-> o_m_axis_tdata[54:0] == 55'd0)
        else $error("plain result carries entry fields");

    a_freed_frame_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[61:55] != 7'd0)
        |-> o_m_axis_tuser == drt_pkg::STS_FRAME)
        else $error("freed count outside a frame step");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second transaction accepted during a scan");
`endif

endmodule

`default_nettype wire

[bench/deferred_reclaim_slot_table_tb.sv]
// ----------------------------------------------------------------------------
// deferred_reclaim_slot_table_tb
// Self-checking bench for the deferred-reclaim slot table. A short table of
// directed transactions (reset state, field extremes, every action, retired
// hits, table full, zero and oversized slot counts) is followed by random
// frames of get-or-create and find requests over small key pools, across
// several slot counts and handshake idling patterns. Each reply is checked
// against fixed values for typed rows, else a behavioral copy of the table.
// ----------------------------------------------------------------------------
module deferred_reclaim_slot_table_tb;

    localparam int NUM_SLOTS    = drt_pkg::SLOTS_DEF;
    localparam int RETIRE_AGE   = drt_pkg::RETIRE_FRAMES_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 131;
    localparam int KEY_POOL     = 8;

    typedef struct packed {
        logic                           is_cfg;
        logic [drt_pkg::CFG_W-1:0]      cfg_val;
        drt_pkg::t_action               act;
        logic [drt_pkg::KEY_W-1:0]      key;
        logic [drt_pkg::RES_W-1:0]      res;
        logic [drt_pkg::GEN_W-1:0]      gen;
        logic                           typed;
        drt_pkg::t_result               want;
    } t_stim_row;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [drt_pkg::S_DATA_W-1:0]       s_tdata = '0;
    logic [1:0]                         s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [drt_pkg::M_DATA_W-1:0]       m_tdata;
    logic [1:0]                         m_tuser;
    logic                               cfg_wr_en = 1'b0;
    logic [drt_pkg::CFG_W-1:0]          cfg_wr_data = '0;

    // table shadow
    logic [drt_pkg::FRAME_W-1:0]        cur_frame;
    logic [drt_pkg::CFG_W-1:0]          active_cfg;
    logic                               tbl_valid [NUM_SLOTS];
    logic [drt_pkg::KEY_W-1:0]          tbl_key [NUM_SLOTS];
    logic [drt_pkg::RES_W-1:0]          tbl_res [NUM_SLOTS];
    logic [drt_pkg::GEN_W-1:0]          tbl_gen [NUM_SLOTS];
    logic [drt_pkg::FRAME_W-1:0]        tbl_last_used [NUM_SLOTS];
    logic [drt_pkg::FRAME_W-1:0]        tbl_retire [NUM_SLOTS];
    logic                               tbl_pending [NUM_SLOTS];

    drt_pkg::t_result                   awaited_replies [$];
    t_stim_row                          stim_table [$];
    int                                 mismatch_count = 0;
    int                                 idle_cycles = 0;
    int                                 send_idle_pct = 0;
    int                                 recv_stall_pct = 0;
    int                                 hold_req = 0;
    int                                 hold_served = 0;
    int                                 frame_ops_left = 0;
    bit                                 in_frame = 1'b0;
    logic [drt_pkg::KEY_W-1:0]          key_pool [KEY_POOL];
    logic [drt_pkg::RES_W-1:0]          res_pool [3];
    logic [drt_pkg::GEN_W-1:0]          gen_pool [3];

    deferred_reclaim_slot_table i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_axis_tvalid  (s_tvalid),
        .o_s_axis_tready  (s_tready),
        .i_s_axis_tdata   (s_tdata),
        .i_s_axis_tuser   (s_tuser),
        .o_m_axis_tvalid  (m_tvalid),
        .i_m_axis_tready  (m_tready),
        .o_m_axis_tdata   (m_tdata),
        .o_m_axis_tuser   (m_tuser),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic drt_pkg::t_result predict_access(drt_pkg::t_action act,
                                                        logic [drt_pkg::KEY_W-1:0] k,
                                                        logic [drt_pkg::RES_W-1:0] r,
                                                        logic [drt_pkg::GEN_W-1:0] g);
        drt_pkg::t_result               o;
        int                             n;
        int                             i;
        int                             found;
        logic [drt_pkg::FRAME_W-1:0]    age;
        o = '0;
        found = -1;
        n = (active_cfg > NUM_SLOTS) ? NUM_SLOTS : active_cfg;
        case (act)
            drt_pkg::ACT_BEGIN: begin
                cur_frame = cur_frame + 1'b1;
                for (i = 0; i < n; i++) begin
                    age = cur_frame - tbl_retire[i];
                    if (tbl_valid[i] && tbl_retire[i] != '0 && age >= RETIRE_AGE) begin
                        tbl_valid[i] = 1'b0;
                        o.freed = o.freed + 1'b1;
                    end
                end
                o.status = drt_pkg::STS_FRAME;
            end
            drt_pkg::ACT_END: begin
                for (i = 0; i < n; i++)
                    if (tbl_valid[i] && tbl_last_used[i] != cur_frame && tbl_retire[i] == '0)
                        tbl_retire[i] = cur_frame;
                o.status = drt_pkg::STS_FRAME;
            end
            drt_pkg::ACT_GET: begin
                for (i = 0; i < n && found < 0; i++)
                    if (tbl_valid[i] && tbl_key[i] == k && tbl_res[i] == r)
                        found = i;
                if (found >= 0) begin
                    if (tbl_gen[found] != g) begin
                        tbl_gen[found] = g;
                        tbl_pending[found] = 1'b1;
                    end
                    tbl_last_used[found] = cur_frame;
                    tbl_retire[found] = '0;
                    o.status = drt_pkg::STS_HIT;
                end else begin
                    for (i = 0; i < n && found < 0; i++)
                        if (!tbl_valid[i])
                            found = i;
                    if (found >= 0) begin
                        tbl_valid[found] = 1'b1;
                        tbl_key[found] = k;
                        tbl_res[found] = r;
                        tbl_gen[found] = g;
                        tbl_last_used[found] = cur_frame;
                        tbl_retire[found] = '0;
                        tbl_pending[found] = 1'b1;
                        o.status = drt_pkg::STS_NEW;
                    end else begin
                        o.status = drt_pkg::STS_MISS;
                    end
                end
            end
            default: begin
                for (i = 0; i < n && found < 0; i++)
                    if (tbl_valid[i] && tbl_key[i] == k && tbl_retire[i] == '0)
                        found = i;
                o.status = (found >= 0) ? drt_pkg::STS_HIT : drt_pkg::STS_MISS;
            end
        endcase
        if (found >= 0 && o.status != drt_pkg::STS_MISS) begin
            o.slot = found[drt_pkg::SLOT_W-1:0];
            o.pending = tbl_pending[found];
            o.res = tbl_res[found];
            o.gen = tbl_gen[found];
        end
        return o;
    endfunction

    function automatic void add_item(drt_pkg::t_action a, logic [drt_pkg::KEY_W-1:0] k,
                                     logic [drt_pkg::RES_W-1:0] r,
                                     logic [drt_pkg::GEN_W-1:0] g);
        t_stim_row row;
        row = '0;
        row.act = a;
        row.key = k;
        row.res = r;
        row.gen = g;
        stim_table.push_back(row);
    endfunction

    function automatic void add_typed(drt_pkg::t_action a, logic [drt_pkg::KEY_W-1:0] k,
                                      logic [drt_pkg::RES_W-1:0] r,
                                      logic [drt_pkg::GEN_W-1:0] g, drt_pkg::t_status s,
                                      logic [drt_pkg::SLOT_W-1:0] sl, logic pd,
                                      logic [drt_pkg::RES_W-1:0] er,
                                      logic [drt_pkg::GEN_W-1:0] eg,
                                      logic [drt_pkg::FREED_W-1:0] fr);
        t_stim_row row;
        row = '0;
        row.act = a;
        row.key = k;
        row.res = r;
        row.gen = g;
        row.typed = 1'b1;
        row.want.status = s;
        row.want.slot = sl;
        row.want.pending = pd;
        row.want.res = er;
        row.want.gen = eg;
        row.want.freed = fr;
        stim_table.push_back(row);
    endfunction

    function automatic void add_cfg(logic [drt_pkg::CFG_W-1:0] v);
        t_stim_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_val = v;
        stim_table.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // hold valid off and wait for every outstanding reply
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (awaited_replies.size() == 0);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [drt_pkg::CFG_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        active_cfg = v;
    endtask

    task automatic drive_item(drt_pkg::t_action a, logic [drt_pkg::KEY_W-1:0] k,
                              logic [drt_pkg::RES_W-1:0] r, logic [drt_pkg::GEN_W-1:0] g,
                              logic typed, drt_pkg::t_result want);
        drt_pkg::t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= a;
        s_tdata <= {g, r, k};
        do @(posedge clk); while (!s_tready);
        pred = predict_access(a, k, r, g);
        awaited_replies.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic make_random(output drt_pkg::t_action a,
                               output logic [drt_pkg::KEY_W-1:0] k,
                               output logic [drt_pkg::RES_W-1:0] r,
                               output logic [drt_pkg::GEN_W-1:0] g);
        if ($urandom_range(9) == 0) begin
            a = drt_pkg::t_action'(2'($urandom_range(3)));
        end else if (frame_ops_left == 0) begin
            if (in_frame) begin
                a = drt_pkg::ACT_END;
            end else begin
                a = drt_pkg::ACT_BEGIN;
                frame_ops_left = $urandom_range(8, 1);
            end
            in_frame = !in_frame;
        end else begin
            a = ($urandom_range(2) != 0) ? drt_pkg::ACT_GET : drt_pkg::ACT_FIND;
            frame_ops_left--;
        end
        k = ($urandom_range(4) != 0) ? key_pool[$urandom_range(KEY_POOL-1)] : $urandom;
        r = ($urandom_range(9) != 0) ? res_pool[$urandom_range(2)]
                                     : drt_pkg::RES_W'($urandom);
        g = ($urandom_range(1) != 0) ? gen_pool[$urandom_range(2)] : $urandom;
    endtask

    initial begin
        forever begin
            @(negedge clk);
            if (hold_served != hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = hold_req;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin : reply_check
        drt_pkg::t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_replies.size() == 0) begin
                $error("reply 0x%0h/0x%0h with no outstanding request", m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("slot_index", want.slot, m_tdata[5:0]);
                check_field("pending_flag", want.pending, m_tdata[6]);
                check_field("entry_resolution", want.res, m_tdata[22:7]);
                check_field("entry_generation", want.gen, m_tdata[54:23]);
                check_field("freed_count", want.freed, m_tdata[61:55]);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                         p;
        int                         k;
        int                         i;
        t_stim_row                  row;
        drt_pkg::t_action           act;
        logic [drt_pkg::KEY_W-1:0]  key;
        logic [drt_pkg::RES_W-1:0]  res;
        logic [drt_pkg::GEN_W-1:0]  gen;
        logic [drt_pkg::CFG_W-1:0]  phase_cfg [PHASES];
        int                         idle_tab [4];
        int                         stall_tab [4];

        cur_frame = '0;
        active_cfg = drt_pkg::CFG_RESET;
        for (i = 0; i < NUM_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_res[i] = '0;
            tbl_gen[i] = '0;
            tbl_last_used[i] = '0;
            tbl_retire[i] = '0;
            tbl_pending[i] = 1'b0;
        end
        phase_cfg = '{7'd127, 7'd4, 7'd64, 7'd1, 7'd0, 7'd9, 7'd64, 7'd2};
        phase_cfg[7] = drt_pkg::CFG_W'($urandom_range(16, 2));
        idle_tab = '{0, 79, 0, 29};
        stall_tab = '{0, 0, 79, 29};

        add_cfg(7'd64);
        add_typed(drt_pkg::ACT_FIND, 32'h0, 16'h0, 32'h0,
                  drt_pkg::STS_MISS, 6'd0, 1'b0, 16'h0, 32'h0, 7'd0);
        add_typed(drt_pkg::ACT_GET, 32'h0, 16'h0, 32'h0,
                  drt_pkg::STS_NEW, 6'd0, 1'b1, 16'h0, 32'h0, 7'd0);
        add_typed(drt_pkg::ACT_END, 32'h0, 16'h0, 32'h0,
                  drt_pkg::STS_FRAME, 6'd0, 1'b0, 16'h0, 32'h0, 7'd0);
        add_typed(drt_pkg::ACT_BEGIN, 32'h0, 16'h0, 32'h0,
                  drt_pkg::STS_FRAME, 6'd0, 1'b0, 16'h0, 32'h0, 7'd0);
        add_typed(drt_pkg::ACT_GET, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                  drt_pkg::STS_NEW, 6'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 7'd0);
        add_typed(drt_pkg::ACT_GET, 32'h0, 16'h0, 32'h5,
                  drt_pkg::STS_HIT, 6'd0, 1'b1, 16'h0, 32'h5, 7'd0);
        add_typed(drt_pkg::ACT_GET, 32'h0, 16'h1, 32'h7,
                  drt_pkg::STS_NEW, 6'd2, 1'b1, 16'h1, 32'h7, 7'd0);
        add_typed(drt_pkg::ACT_FIND, 32'h0, 16'hFFFF, 32'h0,
                  drt_pkg::STS_HIT, 6'd0, 1'b1, 16'h0, 32'h5, 7'd0);
        add_item(drt_pkg::ACT_END, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_item(drt_pkg::ACT_BEGIN, 32'h0, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_GET, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        add_item(drt_pkg::ACT_END, 32'h0, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_FIND, 32'h0, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_GET, 32'h0, 16'h1, 32'h7);
        add_item(drt_pkg::ACT_FIND, 32'h0, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_BEGIN, 32'h0, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_BEGIN, 32'h0, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_BEGIN, 32'h0, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_GET, 32'h1234_5678, 16'h00AA, 32'h1);
        add_cfg(7'd0);
        add_typed(drt_pkg::ACT_GET, 32'h0, 16'h1, 32'h7,
                  drt_pkg::STS_MISS, 6'd0, 1'b0, 16'h0, 32'h0, 7'd0);
        add_typed(drt_pkg::ACT_FIND, 32'hFFFF_FFFF, 16'h0, 32'h0,
                  drt_pkg::STS_MISS, 6'd0, 1'b0, 16'h0, 32'h0, 7'd0);
        add_typed(drt_pkg::ACT_BEGIN, 32'h0, 16'h0, 32'h0,
                  drt_pkg::STS_FRAME, 6'd0, 1'b0, 16'h0, 32'h0, 7'd0);
        add_cfg(7'd1);
        add_item(drt_pkg::ACT_GET, 32'hA5A5_A5A5, 16'h0, 32'h0);
        add_item(drt_pkg::ACT_FIND, 32'h1234_5678, 16'h0, 32'h0);
        add_cfg(7'd127);
        add_item(drt_pkg::ACT_FIND, 32'hFFFF_FFFF, 16'h0, 32'h0);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.is_cfg)
                write_cfg(row.cfg_val);
            else
                drive_item(row.act, row.key, row.res, row.gen, row.typed, row.want);
        end

        for (p = 0; p < PHASES; p++) begin
            write_cfg(phase_cfg[p]);
            send_idle_pct = idle_tab[p % 4];
            recv_stall_pct = stall_tab[p % 4];
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (i = 2; i < KEY_POOL; i++)
                key_pool[i] = $urandom;
            res_pool = '{16'h0, 16'hFFFF, drt_pkg::RES_W'($urandom)};
            gen_pool = '{$urandom, $urandom, 32'hFFFF_FFFF};
            if (p % 4 == 0)
                hold_req++;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2)
                    drain();
                make_random(act, key, res, gen);
                drive_item(act, key, res, gen, 1'b0, '0);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
